// ===== sv/rdt_pkg.sv =====
// shared types and constants for the reloading decrementer timer
// no dependencies; imported by every module of the block
package rdt_pkg;

   localparam int unsigned COUNT_W      = 16;
   localparam int unsigned CLOCKS_W     = 8;
   localparam int unsigned MASK_W       = 4;
   localparam int unsigned REST_W       = 2;
   localparam int unsigned DEC_W        = CLOCKS_W + 1 - REST_W;
   localparam int unsigned REQ_DATA_W   = 32;
   localparam int unsigned RSP_DATA_W   = 24;
   localparam logic [MASK_W-1:0] IRQ_LEVEL = MASK_W'(3);

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_FORCE = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [CLOCKS_W-1:0]       clocks;
      logic [COUNT_W-1:0]        write_value;
      logic [MASK_W-1:0]         interrupt_mask;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        count_value;
      logic [COUNT_W-1:0]        reload_base;
      logic [REST_W-1:0]         prescale_rest;
   } state_type;

   typedef struct packed {
      logic                      irq_taken;
      logic                      expired;
      logic [COUNT_W-1:0]        count_now;
   } rsp_type;

endpackage

// ===== sv/rdt_core.sv =====
// next-state and result logic for one request of the timer
// depends on rdt_pkg
module rdt_core
   import rdt_pkg::*;
(
   input  req_type   req,
   input  state_type state,
   output state_type state_next,
   output rsp_type   rsp
);

   logic [CLOCKS_W:0]   eff;
   logic [DEC_W-1:0]    dec;
   logic [COUNT_W-1:0]  dec_ext;
   logic                enabled;
   logic                hit_zero;

   assign enabled  = (state.reload_base != '0);
   assign eff      = {1'b0, req.clocks} + {{(CLOCKS_W + 1 - REST_W){1'b0}}, state.prescale_rest};
   assign dec      = eff[CLOCKS_W:REST_W];
   assign dec_ext  = {{(COUNT_W - DEC_W){1'b0}}, dec};
   assign hit_zero = (state.count_value <= dec_ext);

   always_comb begin
      state_next    = state;
      rsp.expired   = 1'b0;
      rsp.irq_taken = 1'b0;
      case (req.mode)
         MODE_TICK: begin
            if (enabled) begin
               state_next.prescale_rest = eff[REST_W-1:0];
               if (hit_zero) begin
                  // overshoot plus base, wrapping at the counter width
                  state_next.count_value = state.count_value + state.reload_base - dec_ext;
                  rsp.expired   = 1'b1;
                  rsp.irq_taken = (req.interrupt_mask >= IRQ_LEVEL);
               end else begin
                  state_next.count_value = state.count_value - dec_ext;
               end
            end
         end
         MODE_WRITE: begin
            state_next.reload_base   = req.write_value;
            state_next.count_value   = req.write_value;
            state_next.prescale_rest = '0;
         end
         MODE_FORCE: begin
            if (enabled) begin
               state_next.count_value = '0;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
      rsp.count_now = state_next.count_value;
   end

endmodule

// ===== sv/rdt_out_buf.sv =====
// two-entry result queue that decouples the timer from a stalling receiver
// depends on rdt_pkg
module rdt_out_buf
   import rdt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    pop_valid,
   input  logic    pop_ready,
   output rsp_type pop_data
);

   rsp_type     slot_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  fill_ff;
   logic [1:0]  fill_in;
   logic        pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (fill_ff != 2'd0);
   assign full      = (fill_ff == 2'd2);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/reload_decrementer_timer_top.sv =====
// reloading 16-bit decrementer timer, top level
// depends on rdt_pkg, rdt_core and rdt_out_buf
//
// usage
// - request channel (req_): one request per handshake; tuser carries the mode
//   (tick, write base, force to zero), tdata the clocks, write value and mask
// - response channel (rsp_): exactly one response per request, in order,
//   carrying the counter after the request, the expiry flag and irq taken
// - each response is registered in the output queue and leaves behind any older ones
// - throughput: one request per cycle while the queue is not full; the counter,
//   base and prescaler update in the accepting cycle, so back-to-back ticks see each other
// - a two-entry response queue sits on the output; req_tready is low while both
//   entries are occupied or reset is high, and the queue drops no response
// - reset clears counter, base and prescaler (timer disabled) and empties
//   the queue; no request is taken while reset is high
module reload_decrementer_timer_top
   import rdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] mode
   input  logic [1:0]            req_tuser,
   // [7:0] clocks, [23:8] write_value, [27:24] interrupt_mask, [31:28] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] count_now, [16] expired, [17] irq_taken, [23:18] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   state_type state_ff;
   state_type state_in;
   state_type state_next;
   req_type   req;
   rsp_type   core_rsp;
   rsp_type   buf_rsp;
   logic      accept;
   logic      buf_full;

   assign req.mode           = mode_type'(req_tuser);
   assign req.clocks         = req_tdata[7:0];
   assign req.write_value    = req_tdata[23:8];
   assign req.interrupt_mask = req_tdata[27:24];

   assign req_tready = !buf_full && !reset;
   assign accept     = req_tvalid && req_tready;
   assign state_in   = accept ? state_next : state_ff;

   rdt_core u_core (
      .req        (req),
      .state      (state_ff),
      .state_next (state_next),
      .rsp        (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   rdt_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_rsp),
      .full      (buf_full),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (buf_rsp)
   );

   assign rsp_tdata = {6'd0, buf_rsp.irq_taken, buf_rsp.expired, buf_rsp.count_now};

`ifndef SYNTHESIS
   a_irq_needs_expiry : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!buf_rsp.irq_taken || buf_rsp.expired))
      else $error("irq taken without expiry");

   a_disabled_no_expiry : assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.reload_base == '0) |-> !core_rsp.expired)
      else $error("expiry while timer disabled");

   a_write_clears_rest : assert property (@(posedge clock) disable iff (reset)
      (accept && req.mode == MODE_WRITE) |=>
         (state_ff.prescale_rest == '0 && state_ff.count_value == state_ff.reload_base))
      else $error("write did not load base and counter");

   a_full_blocks : assert property (@(posedge clock) disable iff (reset)
      (buf_full && !rsp_tready) |=> !req_tready)
      else $error("queue drained without a response handshake");

   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("timer state moved without a request");
`endif

endmodule

// ===== tb/sv/reload_decrementer_timer_top_tb.sv =====
// self-checking testbench for reload_decrementer_timer_top: directed table, then random requests
// depends on rdt_pkg and reload_decrementer_timer_top; responses checked against a local timer model or typed rows
`timescale 1ns / 1ps

module reload_decrementer_timer_top_tb;
   import rdt_pkg::*;

   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int         ROWS         = 24;
   localparam int         RANDOM_REQS  = 650;
   localparam int         REPORT_LIMIT = 10;
   localparam int         IDLE_PCT     = 22;
   localparam int         HOLD_AFTER   = ROWS + 400;
   localparam int         HOLD_CYCLES  = 80;

   typedef struct packed {
      logic [1:0]          mode;
      logic [CLOCKS_W-1:0] clocks;
      logic [COUNT_W-1:0]  write_value;
      logic [MASK_W-1:0]   mask;
      logic                typed;
      rsp_type             want;
   } plan_row_type;

   typedef struct packed {
      logic    typed;
      rsp_type want;
   } typed_entry_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser = 2'd0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [COUNT_W-1:0] count_model = '0;
   logic [COUNT_W-1:0] base_model = '0;
   logic [REST_W-1:0]  rest_model = '0;

   rsp_type         awaited_rsp [$];
   typed_entry_type typed_rsp [$];
   int              fault_count = 0;
   int              requests_taken = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;
   bit              calm = 1'b0;

   // directed requests; typed rows carry the response read straight off the spec
   plan_row_type plan [0:ROWS-1] = '{
      '{MODE_TICK,  8'h00, 16'h0000, 4'hF, 1'b1, '{1'b0, 1'b0, 16'h0000}},
      '{MODE_FORCE, 8'h00, 16'h0000, 4'hF, 1'b1, '{1'b0, 1'b0, 16'h0000}},
      '{MODE_SPARE, 8'h55, 16'hAAAA, 4'hF, 1'b1, '{1'b0, 1'b0, 16'h0000}},
      '{MODE_WRITE, 8'h00, 16'hFFFF, 4'hF, 1'b1, '{1'b0, 1'b0, 16'hFFFF}},
      '{MODE_TICK,  8'hFF, 16'h0000, 4'h0, 1'b0, '0},
      '{MODE_TICK,  8'h01, 16'h0000, 4'hF, 1'b0, '0},
      '{MODE_FORCE, 8'h00, 16'h0000, 4'hF, 1'b1, '{1'b0, 1'b0, 16'h0000}},
      '{MODE_TICK,  8'h00, 16'h0000, 4'h3, 1'b1, '{1'b1, 1'b1, 16'hFFFF}},
      '{MODE_FORCE, 8'h00, 16'h0000, 4'h0, 1'b1, '{1'b0, 1'b0, 16'h0000}},
      '{MODE_TICK,  8'h00, 16'h0000, 4'h2, 1'b1, '{1'b0, 1'b1, 16'hFFFF}},
      '{MODE_WRITE, 8'h00, 16'h0001, 4'h0, 1'b1, '{1'b0, 1'b0, 16'h0001}},
      '{MODE_TICK,  8'h04, 16'h0000, 4'hF, 1'b1, '{1'b1, 1'b1, 16'h0001}},
      '{MODE_TICK,  8'hFF, 16'h0000, 4'h3, 1'b0, '0},
      '{MODE_WRITE, 8'h00, 16'h8000, 4'h4, 1'b1, '{1'b0, 1'b0, 16'h8000}},
      '{MODE_TICK,  8'h03, 16'h0000, 4'h4, 1'b0, '0},
      '{MODE_TICK,  8'h01, 16'h0000, 4'h8, 1'b0, '0},
      '{MODE_WRITE, 8'h00, 16'h0000, 4'h0, 1'b1, '{1'b0, 1'b0, 16'h0000}},
      '{MODE_TICK,  8'hFF, 16'h0000, 4'hF, 1'b1, '{1'b0, 1'b0, 16'h0000}},
      '{MODE_FORCE, 8'h00, 16'h0000, 4'hF, 1'b1, '{1'b0, 1'b0, 16'h0000}},
      '{MODE_WRITE, 8'h00, 16'h5A5A, 4'hA, 1'b1, '{1'b0, 1'b0, 16'h5A5A}},
      '{MODE_TICK,  8'hAA, 16'h0000, 4'h5, 1'b0, '0},
      '{MODE_SPARE, 8'h55, 16'hA5A5, 4'hF, 1'b0, '0},
      '{MODE_FORCE, 8'h00, 16'h0000, 4'h3, 1'b1, '{1'b0, 1'b0, 16'h0000}},
      '{MODE_TICK,  8'h01, 16'h0000, 4'h0, 1'b1, '{1'b0, 1'b1, 16'h5A5A}}
   };

   reload_decrementer_timer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type advance_timer(input logic [1:0] mode,
                                             input logic [CLOCKS_W-1:0] clocks,
                                             input logic [COUNT_W-1:0] write_value,
                                             input logic [MASK_W-1:0] mask);
      logic [CLOCKS_W:0]  elapsed;
      logic [DEC_W-1:0]   steps;
      logic [COUNT_W-1:0] steps_ext;
      rsp_type            r;
      r = '0;
      case (mode)
         MODE_TICK: begin
            if (base_model != '0) begin
               elapsed = {1'b0, clocks} + {{(CLOCKS_W + 1 - REST_W){1'b0}}, rest_model};
               steps = elapsed[CLOCKS_W:REST_W];
               steps_ext = {{(COUNT_W - DEC_W){1'b0}}, steps};
               rest_model = elapsed[REST_W-1:0];
               if (count_model <= steps_ext) begin
                  // overshoot plus base, wrapping at 16 bits
                  count_model = count_model + base_model - steps_ext;
                  r.expired = 1'b1;
                  r.irq_taken = (mask >= IRQ_LEVEL);
               end else begin
                  count_model = count_model - steps_ext;
               end
            end
         end
         MODE_WRITE: begin
            base_model = write_value;
            count_model = write_value;
            rest_model = '0;
         end
         MODE_FORCE: begin
            if (base_model != '0) count_model = '0;
         end
         default: ;
      endcase
      r.count_now = count_model;
      return r;
   endfunction

   task automatic note_fault(input string what, input rsp_type want, input rsp_type got);
      if (fault_count < REPORT_LIMIT)
         $display("%0t %s: expected count %h expired %b irq %b, got count %h expired %b irq %b",
                  $time, what, want.count_now, want.expired, want.irq_taken,
                  got.count_now, got.expired, got.irq_taken);
      fault_count++;
   endtask

   task automatic send_request(input logic [1:0] mode, input logic [CLOCKS_W-1:0] clocks,
                               input logic [COUNT_W-1:0] write_value,
                               input logic [MASK_W-1:0] mask, input logic typed,
                               input rsp_type want);
      typed_rsp.push_back('{typed, want});
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {4'b0000, mask, write_value, clocks};
      do @(posedge clock); while (!req_tready);
   endtask

   // checker: responses first, since a response always belongs to an older request
   always @(posedge clock) begin
      rsp_type         got;
      rsp_type         want;
      typed_entry_type known;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[COUNT_W+1:0];
            if (awaited_rsp.size() == 0) begin
               note_fault("response with nothing pending", '0, got);
            end else begin
               want = awaited_rsp.pop_front();
               if (got.count_now !== want.count_now || got.expired !== want.expired ||
                   got.irq_taken !== want.irq_taken)
                  note_fault("response mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            known = typed_rsp.pop_front();
            want = advance_timer(req_tuser, req_tdata[7:0], req_tdata[23:8], req_tdata[27:24]);
            awaited_rsp.push_back(known.typed ? known.want : want);
            requests_taken <= requests_taken + 1;
         end
      end
   end

   // receiver, with one long hold-off so the output queue fills
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && requests_taken >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      int                  i;
      int                  pick;
      int                  sel;
      logic [1:0]          mode;
      logic [CLOCKS_W-1:0] clocks;
      logic [COUNT_W-1:0]  write_value;
      logic [MASK_W-1:0]   mask;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < ROWS; i++)
         send_request(plan[i].mode, plan[i].clocks, plan[i].write_value, plan[i].mask,
                      plan[i].typed, plan[i].want);
      for (i = 0; i < RANDOM_REQS; i++) begin
         calm <= (i >= 150 && i < 270);
         pick = $urandom_range(0, 99);
         clocks = CLOCKS_W'($urandom);
         write_value = COUNT_W'($urandom);
         mask = MASK_W'($urandom_range(0, 15));
         if (pick < 68) begin
            mode = MODE_TICK;
            if ($urandom_range(0, 3) == 0) clocks = CLOCKS_W'($urandom_range(0, 8));
         end else if (pick < 80) begin
            mode = MODE_WRITE;
            sel = $urandom_range(0, 9);
            // short periods so expiry comes often
            if (sel == 0) write_value = '0;
            else if (sel < 6) write_value = COUNT_W'($urandom_range(1, 200));
         end else if (pick < 92) begin
            mode = MODE_FORCE;
         end else begin
            mode = MODE_SPARE;
         end
         send_request(mode, clocks, write_value, mask, 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      calm <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fault_count == 0 && awaited_rsp.size() == 0)
         $display("PASS reload_decrementer_timer_top");
      else
         $display("FAIL reload_decrementer_timer_top");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("FAIL reload_decrementer_timer_top");
      $finish;
   end

endmodule
